### rtl/core/ipv4ft_pkg.sv
`default_nettype none

package ipv4ft_pkg;

    localparam int OFF_W = 16;

    localparam logic [OFF_W-1:0] OFF_MAX     = {OFF_W{1'b1}};
    localparam logic [OFF_W-1:0] OFF_ETH_HI  = 16'd12;
    localparam logic [OFF_W-1:0] OFF_ETH_LO  = 16'd13;
    localparam logic [OFF_W-1:0] OFF_IP_VIHL = 16'd14;
    localparam logic [OFF_W-1:0] OFF_PROTO   = 16'd23;
    localparam logic [OFF_W-1:0] OFF_SADDR   = 16'd26;
    localparam logic [OFF_W-1:0] OFF_DADDR   = 16'd30;

    localparam logic [7:0] ETH_TYPE_HI = 8'h08;
    localparam logic [7:0] ETH_TYPE_LO = 8'h00;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam int ETH_LEN    = 14;
    localparam int IP_MIN_END = 34;
    localparam int TCP_LEN    = 20;
    localparam int UDP_LEN    = 8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        record_valid;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  ip_protocol;
        logic [63:0] frame_total;
    } t_record;

endpackage

`default_nettype wire

### rtl/core/ipv4ft_in_stage.sv
`default_nettype none

module ipv4ft_in_stage (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  ipv4ft_pkg::t_in_item i_item,
    output logic                 o_valid,
    output ipv4ft_pkg::t_in_item o_item,
    input  wire                  i_take
);
    import ipv4ft_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_in_ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ipv4ft_parse.sv
`default_nettype none

module ipv4ft_parse (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  ipv4ft_pkg::t_in_item i_item,
    output logic                 o_take,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output ipv4ft_pkg::t_record  o_record
);
    import ipv4ft_pkg::*;

    logic [OFF_W-1:0] r_offset;
    logic [63:0]      r_count;
    logic [7:0]       r_eth_hi;
    logic [7:0]       r_eth_lo;
    logic [3:0]       r_ihl;
    logic [7:0]       r_proto;
    logic [31:0]      r_saddr;
    logic [31:0]      r_daddr;
    logic [15:0]      r_sport;
    logic [15:0]      r_dport;
    logic             r_out_valid;
    t_record          r_record;

    logic [7:0]       n_eth_hi;
    logic [7:0]       n_eth_lo;
    logic [3:0]       n_ihl;
    logic [7:0]       n_proto;
    logic [31:0]      n_saddr;
    logic [31:0]      n_daddr;
    logic [15:0]      n_sport;
    logic [15:0]      n_dport;
    logic [OFF_W-1:0] n_offset;
    t_record          n_record;

    logic [6:0]       l4_off;
    logic [OFF_W-1:0] l4_wide;
    logic             out_free;
    logic             take_last;
    logic             len_ok;
    logic             eth_ok;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_take      = i_valid && (!i_item.last_byte || out_free);
    assign take_last   = o_take && i_item.last_byte;
    assign o_out_valid = r_out_valid;
    assign o_record    = r_record;

    assign l4_off  = 7'(ETH_LEN) + {1'b0, n_ihl, 2'b00};
    assign l4_wide = OFF_W'(l4_off);

    always_comb begin
        n_eth_hi = (r_offset == OFF_ETH_HI)  ? i_item.data_byte : r_eth_hi;
        n_eth_lo = (r_offset == OFF_ETH_LO)  ? i_item.data_byte : r_eth_lo;
        n_ihl    = (r_offset == OFF_IP_VIHL) ? i_item.data_byte[3:0] : r_ihl;
        n_proto  = (r_offset == OFF_PROTO)   ? i_item.data_byte : r_proto;
        n_saddr  = r_saddr;
        n_daddr  = r_daddr;
        n_sport  = r_sport;
        n_dport  = r_dport;
        for (int k = 0; k < 4; k++) begin
            if (r_offset == OFF_SADDR + OFF_W'(k)) begin
                n_saddr[8*k +: 8] = i_item.data_byte;
            end
            if (r_offset == OFF_DADDR + OFF_W'(k)) begin
                n_daddr[8*k +: 8] = i_item.data_byte;
            end
        end
        if (r_offset == l4_wide) begin
            n_sport[15:8] = i_item.data_byte;
        end
        if (r_offset == l4_wide + OFF_W'(1)) begin
            n_sport[7:0] = i_item.data_byte;
        end
        if (r_offset == l4_wide + OFF_W'(2)) begin
            n_dport[15:8] = i_item.data_byte;
        end
        if (r_offset == l4_wide + OFF_W'(3)) begin
            n_dport[7:0] = i_item.data_byte;
        end
    end

    always_comb begin
        if (i_item.last_byte) begin
            n_offset = '0;
        end else if (r_offset != OFF_MAX) begin
            n_offset = r_offset + OFF_W'(1);
        end else begin
            n_offset = r_offset;
        end
    end

    assign len_ok = r_offset >= OFF_W'(IP_MIN_END - 1);
    assign eth_ok = (n_eth_hi == ETH_TYPE_HI) && (n_eth_lo == ETH_TYPE_LO);

    always_comb begin
        n_record             = '0;
        n_record.frame_total = r_count + 64'd1;
        if (len_ok && eth_ok) begin
            n_record.record_valid = 1'b1;
            if (n_proto == PROTO_TCP) begin
                if (r_offset < l4_wide + OFF_W'(TCP_LEN - 1)) begin
                    n_record.record_valid = 1'b0;
                end
            end else if (n_proto == PROTO_UDP) begin
                if (r_offset < l4_wide + OFF_W'(UDP_LEN - 1)) begin
                    n_record.record_valid = 1'b0;
                end
            end
            if (n_record.record_valid) begin
                n_record.source_address = n_saddr;
                n_record.dest_address   = n_daddr;
                n_record.ip_protocol    = n_proto;
                if (n_proto == PROTO_TCP || n_proto == PROTO_UDP) begin
                    n_record.source_port = n_sport;
                    n_record.dest_port   = n_dport;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_offset <= n_offset;
            end
            if (take_last) begin
                r_count     <= r_count + 64'd1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_eth_hi <= n_eth_hi;
            r_eth_lo <= n_eth_lo;
            r_ihl    <= n_ihl;
            r_proto  <= n_proto;
            r_saddr  <= n_saddr;
            r_daddr  <= n_daddr;
            r_sport  <= n_sport;
            r_dport  <= n_dport;
        end
        if (take_last) begin
            r_record <= n_record;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ipv4_five_tuple_extractor.sv
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_data_byte, i_last_byte
// out       output     o_out_valid / i_out_ready  o_record_valid, o_source_address,
//                                                 o_dest_address, o_source_port,
//                                                 o_dest_port, o_ip_protocol,
//                                                 o_frame_total
//
// One byte per cycle sustained unless a stalled result holds a last byte; each byte is
// first registered at the input; a frame's last byte then goes to the result register.
// Header fields are captured by byte offset (ports after the IHL) as the frame streams.
// Synchronous active-low reset clears the byte offset, frame counter and valid flags.
// A stalled result holds only last bytes; other bytes keep flowing.
`default_nettype none

module ipv4_five_tuple_extractor (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_last_byte,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic        o_record_valid,
    output logic [31:0] o_source_address,
    output logic [31:0] o_dest_address,
    output logic [15:0] o_source_port,
    output logic [15:0] o_dest_port,
    output logic [7:0]  o_ip_protocol,
    output logic [63:0] o_frame_total
);
    import ipv4ft_pkg::*;

    t_in_item in_item;
    t_in_item stage_item;
    t_record  record;
    logic     stage_valid;
    logic     stage_take;

    assign in_item.data_byte = i_data_byte;
    assign in_item.last_byte = i_last_byte;

    ipv4ft_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_item     (in_item),
        .o_valid    (stage_valid),
        .o_item     (stage_item),
        .i_take     (stage_take)
    );

    ipv4ft_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stage_valid),
        .i_item      (stage_item),
        .o_take      (stage_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_record    (record)
    );

    assign o_record_valid   = record.record_valid;
    assign o_source_address = record.source_address;
    assign o_dest_address   = record.dest_address;
    assign o_source_port    = record.source_port;
    assign o_dest_port      = record.dest_port;
    assign o_ip_protocol    = record.ip_protocol;
    assign o_frame_total    = record.frame_total;

endmodule

`default_nettype wire

### test/tb_ipv4_five_tuple_extractor.sv
`default_nettype none

module tb_ipv4_five_tuple_extractor;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4ft_pkg::*;

    localparam int HEAD_BYTES = 78;
    localparam int MAX_REPORTS = 10;
    localparam int TAIL_CYCLES = 8;

    typedef logic [7:0] t_frame_bytes[$];

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_record_valid;
    logic [31:0] o_source_address;
    logic [31:0] o_dest_address;
    logic [15:0] o_source_port;
    logic [15:0] o_dest_port;
    logic [7:0]  o_ip_protocol;
    logic [63:0] o_frame_total;

    ipv4_five_tuple_extractor dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_record_valid   (o_record_valid),
        .o_source_address (o_source_address),
        .o_dest_address   (o_dest_address),
        .o_source_port    (o_source_port),
        .o_dest_port      (o_dest_port),
        .o_ip_protocol    (o_ip_protocol),
        .o_frame_total    (o_frame_total)
    );

    logic [7:0]  frame_head[HEAD_BYTES];
    logic [15:0] byte_pos;
    logic [63:0] frames_seen;
    t_record     pending_records[$];

    int mismatches;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("ipv4_five_tuple_extractor test failed");
        $finish;
    end

    task automatic track_frame_byte(input logic [7:0] data, input logic last);
        t_record     rec;
        int unsigned len;
        int unsigned l4;
        int unsigned need;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic        ok;
        if (byte_pos < HEAD_BYTES) begin
            frame_head[byte_pos] = data;
        end
        if (!last) begin
            if (byte_pos != OFF_MAX) begin
                byte_pos = byte_pos + 16'd1;
            end
        end else begin
            len = int'(byte_pos) + 1;
            byte_pos = '0;
            frames_seen = frames_seen + 64'd1;
            rec = '0;
            rec.frame_total = frames_seen;
            if (len >= IP_MIN_END && frame_head[OFF_ETH_HI] == ETH_TYPE_HI &&
                frame_head[OFF_ETH_LO] == ETH_TYPE_LO) begin
                ihl = frame_head[OFF_IP_VIHL][3:0];
                l4 = ETH_LEN + 4 * ihl;
                proto = frame_head[OFF_PROTO];
                ok = 1'b1;
                if (proto == PROTO_TCP || proto == PROTO_UDP) begin
                    need = l4 + ((proto == PROTO_TCP) ? TCP_LEN : UDP_LEN);
                    if (len < need) begin
                        ok = 1'b0;
                    end else begin
                        rec.source_port = {frame_head[l4], frame_head[l4 + 1]};
                        rec.dest_port = {frame_head[l4 + 2], frame_head[l4 + 3]};
                    end
                end
                if (ok) begin
                    rec.record_valid = 1'b1;
                    rec.source_address = {frame_head[29], frame_head[28],
                                          frame_head[27], frame_head[26]};
                    rec.dest_address = {frame_head[33], frame_head[32],
                                        frame_head[31], frame_head[30]};
                    rec.ip_protocol = proto;
                end else begin
                    rec.source_port = '0;
                    rec.dest_port = '0;
                end
            end
            pending_records.push_back(rec);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            track_frame_byte(i_data_byte, i_last_byte);
        end
    end

    always @(posedge i_clk) begin
        t_record got;
        t_record want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_record_valid, o_source_address, o_dest_address, o_source_port,
                   o_dest_port, o_ip_protocol, o_frame_total};
            if (pending_records.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected record: v=%b sa=%h da=%h sp=%h dp=%h pr=%h ft=%0d",
                             got.record_valid, got.source_address, got.dest_address,
                             got.source_port, got.dest_port, got.ip_protocol,
                             got.frame_total);
                end
            end else begin
                want = pending_records.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("record mismatch: exp v=%b sa=%h da=%h sp=%h dp=%h pr=%h ft=%0d",
                                 want.record_valid, want.source_address, want.dest_address,
                                 want.source_port, want.dest_port, want.ip_protocol,
                                 want.frame_total);
                        $display("                 got v=%b sa=%h da=%h sp=%h dp=%h pr=%h ft=%0d",
                                 got.record_valid, got.source_address, got.dest_address,
                                 got.source_port, got.dest_port, got.ip_protocol,
                                 got.frame_total);
                    end
                end
            end
        end
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                i_out_ready = 1'b0;
            end else if (hold_cycles > 0) begin
                i_out_ready = 1'b0;
                hold_cycles--;
            end else begin
                i_out_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_data_byte = data;
        i_last_byte = last;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_frame(ref t_frame_bytes bytes);
        for (int i = 0; i < bytes.size(); i++) begin
            send_byte(bytes[i], i == bytes.size() - 1);
        end
    endtask

    task automatic make_frame(ref t_frame_bytes bytes, input int len, input logic [15:0] etype,
                              input logic [7:0] vihl, input logic [7:0] proto,
                              input int fill);
        bytes.delete();
        for (int i = 0; i < len; i++) begin
            bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
        end
        if (len > OFF_ETH_HI) bytes[OFF_ETH_HI] = etype[15:8];
        if (len > OFF_ETH_LO) bytes[OFF_ETH_LO] = etype[7:0];
        if (len > OFF_IP_VIHL) bytes[OFF_IP_VIHL] = vihl;
        if (len > OFF_PROTO) bytes[OFF_PROTO] = proto;
    endtask

    task automatic random_frame(ref t_frame_bytes bytes);
        int         len;
        int         need;
        logic [3:0] ihl;
        logic [7:0] proto;
        logic [15:0] etype;
        if ($urandom_range(99) < 70) begin
            ihl = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd5;
            case ($urandom_range(3))
                0, 1: proto = PROTO_TCP;
                2: proto = PROTO_UDP;
                default: proto = 8'($urandom);
            endcase
            etype = ($urandom_range(9) == 0) ? 16'($urandom) : {ETH_TYPE_HI, ETH_TYPE_LO};
            need = ETH_LEN + 4 * ihl;
            if (proto == PROTO_TCP) need += TCP_LEN;
            if (proto == PROTO_UDP) need += UDP_LEN;
            if (need < IP_MIN_END) need = IP_MIN_END;
            if ($urandom_range(4) == 0) begin
                len = need - $urandom_range(1, 3);
            end else begin
                len = need + $urandom_range(0, 12);
            end
            make_frame(bytes, len, etype, {4'h4, ihl}, proto, -1);
        end else begin
            len = $urandom_range(1, 90);
            etype = $urandom_range(1) ? {ETH_TYPE_HI, ETH_TYPE_LO} : 16'($urandom);
            make_frame(bytes, len, etype, 8'($urandom), 8'($urandom), -1);
        end
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic wait_for_records;
        while (pending_records.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic test_directed_frames;
        t_frame_bytes f;
        set_idling(0, 0);
        make_frame(f, 54, 16'h0800, 8'h45, PROTO_TCP, -1);
        send_frame(f);
        make_frame(f, 53, 16'h0800, 8'h45, PROTO_TCP, -1);
        send_frame(f);
        make_frame(f, 42, 16'h0800, 8'h45, PROTO_UDP, 8'hFF);
        send_frame(f);
        make_frame(f, 41, 16'h0800, 8'h45, PROTO_UDP, -1);
        send_frame(f);
        make_frame(f, 34, 16'h0800, 8'h45, 8'd1, 8'h00);
        send_frame(f);
        make_frame(f, 33, 16'h0800, 8'h45, 8'd1, -1);
        send_frame(f);
        make_frame(f, 34, 16'h0900, 8'h45, 8'd1, -1);
        send_frame(f);
        make_frame(f, 34, 16'h0801, 8'h45, 8'd1, -1);
        send_frame(f);
        make_frame(f, 34, 16'h0800, 8'h40, PROTO_TCP, -1);
        send_frame(f);
        make_frame(f, 82, 16'h0800, 8'h4F, PROTO_UDP, 8'hFF);
        send_frame(f);
        make_frame(f, 80, 16'h0800, 8'h4F, PROTO_TCP, -1);
        send_frame(f);
        make_frame(f, 1, 16'h0000, 8'h00, 8'h00, 8'hFF);
        send_frame(f);
        make_frame(f, 1, 16'h0000, 8'h00, 8'h00, 8'h00);
        send_frame(f);
        wait_for_records();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int min_bytes, input int min_frames);
        t_frame_bytes f;
        int           bytes_sent;
        int           frames_sent;
        set_idling(send_pct, recv_pct);
        bytes_sent = 0;
        frames_sent = 0;
        while (bytes_sent < min_bytes || frames_sent < min_frames) begin
            random_frame(f);
            send_frame(f);
            bytes_sent += f.size();
            frames_sent++;
        end
    endtask

    task automatic test_backpressure;
        t_frame_bytes f;
        set_idling(0, 0);
        hold_cycles = 500;
        for (int n = 0; n < 16; n++) begin
            if (n % 8 == 0) begin
                make_frame(f, 54, 16'h0800, 8'h45, PROTO_TCP, -1);
            end else begin
                make_frame(f, $urandom_range(1, 3), 16'($urandom), 8'($urandom),
                           8'($urandom), -1);
            end
            send_frame(f);
        end
        wait_for_records();
    endtask

    task automatic test_drain_pause;
        t_frame_bytes f;
        set_idling(6, 6);
        random_frame(f);
        send_frame(f);
        wait_for_records();
        random_frame(f);
        send_frame(f);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        byte_pos = '0;
        frames_seen = '0;
        mismatches = 0;
        hold_cycles = 0;
        set_idling(0, 0);
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed_frames();
        test_random_traffic(0, 0, 40, 1);
        test_random_traffic(87, 0, 40, 1);
        test_random_traffic(0, 87, 40, 1);
        test_random_traffic(6, 6, 40, 1);
        test_backpressure();
        test_drain_pause();

        i_in_valid = 1'b0;
        wait_for_records();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_records.size() == 0) begin
            $display("ipv4_five_tuple_extractor test passed");
        end else begin
            $display("ipv4_five_tuple_extractor test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
